// File: rtl/tbrs_pkg.sv
`default_nettype none

package tbrs_pkg;

  localparam int MAX_RUNS = 256;
  localparam int BUFFER_BYTES = 65536;
  localparam int RUNS_W = $clog2(MAX_RUNS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [16:0] LAST_POS = 17'(BUFFER_BYTES - 1);

  localparam logic [1:0] CLS_PRINT = 2'd0;
  localparam logic [1:0] CLS_ESC = 2'd1;
  localparam logic [1:0] CLS_UTF8 = 2'd2;

  localparam logic REC_RUN = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_CSI = 8'h5B;
  localparam logic [7:0] BYTE_ST = 8'h5C;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_AFTER_ESC = 6'b000010,
    PH_CSI       = 6'b000100,
    PH_STR       = 6'b001000,
    PH_STR_ESC   = 6'b010000,
    PH_INTER     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_in_buffer;
  } byte_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [1:0]  run_type;
    logic [15:0] run_offset;
    logic [16:0] run_length;
    logic [16:0] covered_bytes;
    logic        last_result;
  } rec_item_t;

  typedef struct packed {
    logic [1:0]  run_type;
    logic [15:0] run_offset;
    logic [16:0] run_length;
    logic [16:0] covered_bytes;
  } run_rec_t;

  typedef struct packed {
    logic        has_a;
    run_rec_t    rec_a;
    logic        has_b;
    run_rec_t    rec_b;
    logic        has_sum;
    logic [16:0] sum_covered;
  } bundle_t;

endpackage

`default_nettype wire

// File: rtl/tbrs_front.sv
`default_nettype none

module tbrs_front import tbrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire byte_item_t byte_item,
  input  wire logic       q_full,
  output logic            q_push,
  output bundle_t         q_data
);

  logic [16:0]       byte_position, byte_position_next;
  logic              run_open, run_open_next;
  logic [1:0]        current_class, current_class_next;
  logic [15:0]       run_begin, run_begin_next;
  logic [16:0]       committed_end, committed_end_next;
  phase_t            sequence_phase, sequence_phase_next;
  logic [1:0]        continuations_left, continuations_left_next;
  logic [RUNS_W-1:0] runs_emitted, runs_emitted_next;
  logic              halted, halted_next;

  logic [7:0]  b;
  logic [16:0] p_inc;
  logic        last;
  logic        fresh;
  logic        seq_done;
  phase_t      phase_adv;
  logic [1:0]  cls;
  logic        accept;
  bundle_t     bundle;

  assign byte_ready = !q_full;
  assign accept = byte_valid && byte_ready;
  assign b = byte_item.byte_value;
  assign p_inc = 17'(byte_position + 17'd1);
  assign last = byte_item.last_in_buffer || (byte_position >= LAST_POS);

  always_comb begin
    phase_adv = sequence_phase;
    seq_done = 1'b0;
    case (sequence_phase)
      PH_AFTER_ESC: begin
        if (b == BYTE_CSI) begin
          phase_adv = PH_CSI;
        end else if (b inside {8'h5D, 8'h50, 8'h5F, 8'h5E, 8'h6B}) begin
          phase_adv = PH_STR;
        end else if (b inside {[8'h20:8'h2F]}) begin
          phase_adv = PH_INTER;
        end else begin
          seq_done = 1'b1;
        end
      end
      PH_CSI: begin
        seq_done = b inside {[8'h40:8'h7E]};
      end
      PH_STR: begin
        if (b == BYTE_BEL) begin
          seq_done = 1'b1;
        end else if (b == BYTE_ESC) begin
          phase_adv = PH_STR_ESC;
        end
      end
      PH_STR_ESC: begin
        if (b == BYTE_ST || b == BYTE_BEL) begin
          seq_done = 1'b1;
        end else if (b != BYTE_ESC) begin
          phase_adv = PH_STR;
        end
      end
      default: begin
        seq_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (b inside {[8'h20:8'h7E]}) begin
      cls = CLS_PRINT;
    end else if (b[7]) begin
      cls = CLS_UTF8;
    end else begin
      cls = CLS_ESC;
    end
  end

  always_comb begin
    byte_position_next = p_inc;
    run_open_next = run_open;
    current_class_next = current_class;
    run_begin_next = run_begin;
    committed_end_next = committed_end;
    sequence_phase_next = sequence_phase;
    continuations_left_next = continuations_left;
    runs_emitted_next = runs_emitted;
    halted_next = halted;
    fresh = 1'b1;
    bundle = '0;

    if (!halted) begin
      if (run_open && current_class == CLS_ESC && sequence_phase != PH_IDLE) begin
        fresh = 1'b0;
        if (seq_done) begin
          sequence_phase_next = PH_IDLE;
          committed_end_next = p_inc;
        end else begin
          sequence_phase_next = phase_adv;
        end
      end else if (run_open && current_class == CLS_UTF8 && continuations_left != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          continuations_left_next = 2'(continuations_left - 2'd1);
          if (continuations_left_next == 2'd0) begin
            committed_end_next = p_inc;
          end
          fresh = 1'b0;
        end else begin
          continuations_left_next = 2'd0;
          committed_end_next = byte_position;
        end
      end

      if (fresh) begin
        if (run_open_next && cls != current_class_next) begin
          if (committed_end_next > {1'b0, run_begin_next}) begin
            bundle.has_a = 1'b1;
            bundle.rec_a.run_type = current_class_next;
            bundle.rec_a.run_offset = run_begin_next;
            bundle.rec_a.run_length = 17'(committed_end_next - {1'b0, run_begin_next});
            bundle.rec_a.covered_bytes = committed_end_next;
            runs_emitted_next = RUNS_W'(runs_emitted_next + 1'b1);
            if (runs_emitted_next >= RUNS_W'(MAX_RUNS)) begin
              halted_next = 1'b1;
            end
          end
          run_open_next = 1'b0;
          sequence_phase_next = PH_IDLE;
          continuations_left_next = 2'd0;
        end
        if (!halted_next) begin
          if (!run_open_next) begin
            run_open_next = 1'b1;
            current_class_next = cls;
            run_begin_next = byte_position[15:0];
            committed_end_next = byte_position;
          end
          if (cls == CLS_PRINT) begin
            committed_end_next = p_inc;
          end else if (cls == CLS_UTF8) begin
            if (b[7:5] == 3'b110) begin
              continuations_left_next = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              continuations_left_next = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
              continuations_left_next = 2'd3;
            end else begin
              committed_end_next = p_inc;
            end
          end else if (b == BYTE_ESC) begin
            sequence_phase_next = PH_AFTER_ESC;
          end else begin
            committed_end_next = p_inc;
          end
        end
      end
    end

    if (last) begin
      if (run_open_next && committed_end_next > {1'b0, run_begin_next}) begin
        bundle.has_b = 1'b1;
        bundle.rec_b.run_type = current_class_next;
        bundle.rec_b.run_offset = run_begin_next;
        bundle.rec_b.run_length = 17'(committed_end_next - {1'b0, run_begin_next});
        bundle.rec_b.covered_bytes = committed_end_next;
      end
      bundle.has_sum = 1'b1;
      bundle.sum_covered = committed_end_next;
      byte_position_next = '0;
      run_open_next = 1'b0;
      current_class_next = CLS_PRINT;
      run_begin_next = '0;
      committed_end_next = '0;
      sequence_phase_next = PH_IDLE;
      continuations_left_next = 2'd0;
      runs_emitted_next = '0;
      halted_next = 1'b0;
    end
  end

  assign q_push = accept && (bundle.has_a || bundle.has_sum);
  assign q_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      run_open <= 1'b0;
      current_class <= CLS_PRINT;
      run_begin <= '0;
      committed_end <= '0;
      sequence_phase <= PH_IDLE;
      continuations_left <= 2'd0;
      runs_emitted <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      run_open <= run_open_next;
      current_class <= current_class_next;
      run_begin <= run_begin_next;
      committed_end <= committed_end_next;
      sequence_phase <= sequence_phase_next;
      continuations_left <= continuations_left_next;
      runs_emitted <= runs_emitted_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tbrs_queue.sv
`default_nettype none

module tbrs_queue import tbrs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output bundle_t      head,
  output logic         head_valid
);

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tbrs_back.sv
`default_nettype none

module tbrs_back import tbrs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t head,
  input  wire logic    head_valid,
  output logic         pop,
  output logic         rec_valid,
  input  wire logic    rec_ready,
  output rec_item_t    rec_item
);

  logic      sent_a;
  logic      sent_b;
  logic      want_a;
  logic      want_b;
  logic      load;
  logic      final_rec;
  rec_item_t rec_sel;

  assign want_a = head.has_a && !sent_a;
  assign want_b = head.has_b && !sent_b;
  assign load = head_valid && (!rec_valid || rec_ready);

  always_comb begin
    rec_sel = '0;
    final_rec = 1'b1;
    if (want_a) begin
      final_rec = !head.has_sum;
      rec_sel.record_kind = REC_RUN;
      rec_sel.run_type = head.rec_a.run_type;
      rec_sel.run_offset = head.rec_a.run_offset;
      rec_sel.run_length = head.rec_a.run_length;
      rec_sel.covered_bytes = head.rec_a.covered_bytes;
    end else if (want_b) begin
      final_rec = 1'b0;
      rec_sel.record_kind = REC_RUN;
      rec_sel.run_type = head.rec_b.run_type;
      rec_sel.run_offset = head.rec_b.run_offset;
      rec_sel.run_length = head.rec_b.run_length;
      rec_sel.covered_bytes = head.rec_b.covered_bytes;
    end else begin
      rec_sel.record_kind = REC_SUMMARY;
      rec_sel.covered_bytes = head.sum_covered;
    end
    rec_sel.last_result = final_rec;
  end

  assign pop = load && final_rec;

  always_ff @(posedge clk) begin
    if (load) begin
      rec_item <= rec_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      sent_a <= 1'b0;
      sent_b <= 1'b0;
    end else if (load) begin
      rec_valid <= 1'b1;
      if (final_rec) begin
        sent_a <= 1'b0;
        sent_b <= 1'b0;
      end else if (want_a) begin
        sent_a <= 1'b1;
      end else begin
        sent_b <= 1'b1;
      end
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/terminal_byte_run_segmenter_unit.sv
// Splits a terminal-output buffer into runs of printable, control/escape and UTF-8
// bytes, one byte accepted per cycle. A byte that closes a run, or the last byte of
// a buffer, yields a bundle of up to three records that waits in a two-entry queue;
// the output stage sends one record per cycle, so with the output ready the input
// stalls only while bundles of two or three records drain. A byte's first record
// is written into the queue, then into the output register, and then presented.
`default_nettype none

module terminal_byte_run_segmenter_unit import tbrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire byte_item_t byte_item,
  output logic            rec_valid,
  input  wire logic       rec_ready,
  output rec_item_t       rec_item
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_head_valid;
  bundle_t q_data;
  bundle_t q_head;

  tbrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  tbrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  tbrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_item   (rec_item)
  );

endmodule

`default_nettype wire

// File: rtl/tbrs_checker.sv
`default_nettype none

module tbrs_checker import tbrs_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       byte_valid,
  input wire logic       byte_ready,
  input wire byte_item_t byte_item,
  input wire logic       rec_valid,
  input wire logic       rec_ready,
  input wire rec_item_t  rec_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> rec_valid && $stable(rec_item))
    else $error("result item changed while stalled");

  a_summary_shape: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_item.record_kind == REC_SUMMARY |->
      rec_item.last_result && rec_item.run_length == 17'd0 &&
      rec_item.run_offset == 16'd0 && rec_item.run_type == CLS_PRINT)
    else $error("malformed summary item");

  a_run_span: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec_item.record_kind == REC_RUN |->
      rec_item.run_length != 17'd0 &&
      rec_item.covered_bytes == 17'({1'b0, rec_item.run_offset} + rec_item.run_length))
    else $error("run item span inconsistent");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rec_valid)
    else $error("result item shown right after reset");

endmodule

bind terminal_byte_run_segmenter_unit tbrs_checker u_tbrs_checker (.*);

`default_nettype wire
